/* rtl/ltrie_pkg.sv */
// shared types and constants for the letter trie block
// no dependencies; the interfaces, the trie block and the testbench refer to this package by scoped names
package ltrie_pkg;

    localparam int NODES_DEF    = 1024;
    localparam int ALPHABET_DEF = 26;

    // fixed payload widths
    localparam int FUNC_W   = 2;
    localparam int LETTER_W = 5;
    localparam int STATUS_W = 2;
    localparam int MASK_W   = 26;
    localparam int CURSOR_W = 10;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_LOOKUP = 2'd1,
        FUNC_REPORT = 2'd2,
        FUNC_RESET  = 2'd3
    } t_func;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MISSING = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PTR,
        S_MASK,
        S_ALLOC,
        S_OUT
    } t_state;

endpackage

/* rtl/ltrie_if.sv */
// valid/ready channel interfaces for the letter trie command and result streams
// depends on ltrie_pkg for the payload widths
interface ltrie_in_if;
    logic                              valid;
    logic                              ready;
    logic [ltrie_pkg::FUNC_W-1:0]      func;
    logic [ltrie_pkg::LETTER_W-1:0]    letter;

    modport source (output valid, output func, output letter, input ready);
    modport sink   (input valid, input func, input letter, output ready);
endinterface

interface ltrie_out_if;
    logic                              valid;
    logic                              ready;
    logic [ltrie_pkg::STATUS_W-1:0]    status;
    logic [ltrie_pkg::MASK_W-1:0]      child_mask;
    logic [ltrie_pkg::CURSOR_W-1:0]    cursor_node;

    modport source (output valid, output status, output child_mask, output cursor_node,
                    input ready);
    modport sink   (input valid, input status, input child_mask, input cursor_node,
                    output ready);
endinterface

/* rtl/letter_trie_insert_lookup.sv */
// Letter trie with a cursor. Each command moves or queries one cursor node in a
// pool of NODES nodes: insert follows the child for a letter and allocates a
// fresh node when it is absent, lookup follows it and raises a sticky
// path-missing status when it is absent, report returns the cursor's child
// mask and reset-cursor goes back to the root and clears the error. Child
// pointers live in one ram (NODES*ALPHABET entries, registered read) and child
// masks in a second ram (NODES entries). The cursor's own mask is kept in a
// register, so report, errors, a full pool and commands ignored under the sticky
// error go straight to the result state; reset makes one mask ram read of the
// root and an insert that allocates makes two mask ram writes (parent, then the
// fresh node); following an existing child reads the pointer ram, then the mask
// ram at the address it returns. One result is produced per command, and the
// result register lets the next command start while a result waits. There is
// no clearing pass after reset: a node's mask is written to zero when the node
// is allocated, and the root's mask reads as zero until it is first written.
// Depends on ltrie_pkg, ltrie_if and ltrie_ram.
module letter_trie_insert_lookup #(
    parameter int NODES    = ltrie_pkg::NODES_DEF,
    parameter int ALPHABET = ltrie_pkg::ALPHABET_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ltrie_in_if.sink      i_in,
    ltrie_out_if.source   o_out
);

    localparam int NW    = $clog2(NODES);          // node index width
    localparam int CW    = $clog2(NODES + 1);      // node count width
    localparam int SLOTS = NODES * ALPHABET;
    localparam int SW    = $clog2(SLOTS);          // pointer ram address width

    // fsm and control state
    ltrie_pkg::t_state r_state, n_state;
    logic [NW-1:0]       r_cursor, n_cursor;
    logic [ALPHABET-1:0] r_cur_mask, n_cur_mask;   // mask of the cursor node
    logic [CW-1:0]       r_count, n_count;         // allocated nodes
    logic                r_err, n_err;             // sticky path-missing
    logic                r_full, n_full;           // current transaction hit a full pool
    logic                r_root_init, n_root_init; // root mask written at least once

    // result register
    logic                            r_out_valid, n_out_valid;
    logic [ltrie_pkg::STATUS_W-1:0]  r_status, n_status;
    logic [ltrie_pkg::MASK_W-1:0]    r_mask_out, n_mask_out;
    logic [ltrie_pkg::CURSOR_W-1:0]  r_node_out, n_node_out;

    // ram ports
    logic                ptr_we;
    logic [SW-1:0]       ptr_addr;
    logic [NW-1:0]       ptr_rdata;
    logic                msk_we;
    logic [NW-1:0]       msk_waddr;
    logic [ALPHABET-1:0] msk_wdata;
    logic [NW-1:0]       msk_raddr;
    logic [ALPHABET-1:0] msk_rdata;

    // command decode
    logic                in_accept;
    ltrie_pkg::t_func    in_func;
    logic [ALPHABET-1:0] letter_bit;
    logic                has_child;
    logic                letter_oor;
    logic                pool_full;
    logic [NW-1:0]       fresh;
    logic                out_free;
    logic [ltrie_pkg::MASK_W-1:0]   mask_ext;
    logic [ltrie_pkg::CURSOR_W-1:0] node_ext;

    assign i_in.ready = (r_state == ltrie_pkg::S_IDLE);
    assign in_accept  = i_in.valid && i_in.ready;
    assign in_func    = ltrie_pkg::t_func'(i_in.func);
    assign letter_bit = ALPHABET'(1) << i_in.letter;
    assign has_child  = |(r_cur_mask & letter_bit);
    assign letter_oor = 7'(i_in.letter) >= 7'(ALPHABET);
    assign pool_full  = r_count >= CW'(NODES);
    assign fresh      = r_count[NW-1:0];
    assign out_free   = !r_out_valid || o_out.ready;

    // slot of the cursor's child pointer for this letter
    assign ptr_addr = SW'(r_cursor) * SW'(ALPHABET) + SW'(i_in.letter);

    // after a pointer read the mask of the target node is fetched; otherwise root
    assign msk_raddr = (r_state == ltrie_pkg::S_PTR) ? ptr_rdata : NW'(0);

    // fit the internal mask and node index to the fixed result widths
    generate
        if (ALPHABET >= ltrie_pkg::MASK_W) begin : g_mask_trunc
            assign mask_ext = r_cur_mask[ltrie_pkg::MASK_W-1:0];
        end else begin : g_mask_ext
            assign mask_ext = ltrie_pkg::MASK_W'(r_cur_mask);
        end
        if (NW >= ltrie_pkg::CURSOR_W) begin : g_node_trunc
            assign node_ext = r_cursor[ltrie_pkg::CURSOR_W-1:0];
        end else begin : g_node_ext
            assign node_ext = ltrie_pkg::CURSOR_W'(r_cursor);
        end
    endgenerate

    ltrie_ram #(
        .DEPTH (SLOTS),
        .WIDTH (NW)
    ) u_ptr_ram (
        .i_clk   (i_clk),
        .i_we    (ptr_we),
        .i_waddr (ptr_addr),
        .i_wdata (fresh),
        .i_raddr (ptr_addr),
        .o_rdata (ptr_rdata)
    );

    ltrie_ram #(
        .DEPTH (NODES),
        .WIDTH (ALPHABET)
    ) u_mask_ram (
        .i_clk   (i_clk),
        .i_we    (msk_we),
        .i_waddr (msk_waddr),
        .i_wdata (msk_wdata),
        .i_raddr (msk_raddr),
        .o_rdata (msk_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ltrie_pkg::S_IDLE: begin
                if (in_accept) begin
                    unique case (in_func)
                        ltrie_pkg::FUNC_RESET:  n_state = ltrie_pkg::S_MASK;
                        ltrie_pkg::FUNC_REPORT: n_state = ltrie_pkg::S_OUT;
                        ltrie_pkg::FUNC_INSERT,
                        ltrie_pkg::FUNC_LOOKUP: begin
                            if (r_err || letter_oor) begin
                                n_state = ltrie_pkg::S_OUT;
                            end else if (has_child) begin
                                n_state = ltrie_pkg::S_PTR;
                            end else if (in_func == ltrie_pkg::FUNC_LOOKUP || pool_full) begin
                                n_state = ltrie_pkg::S_OUT;
                            end else begin
                                n_state = ltrie_pkg::S_ALLOC;
                            end
                        end
                        default: n_state = ltrie_pkg::S_OUT;
                    endcase
                end
            end
            ltrie_pkg::S_PTR:   n_state = ltrie_pkg::S_MASK;
            ltrie_pkg::S_MASK:  n_state = ltrie_pkg::S_OUT;
            ltrie_pkg::S_ALLOC: n_state = ltrie_pkg::S_OUT;
            ltrie_pkg::S_OUT: begin
                if (out_free) begin
                    n_state = ltrie_pkg::S_IDLE;
                end
            end
            default: n_state = ltrie_pkg::S_IDLE;
        endcase
    end

    // datapath and ram controls
    always_comb begin
        n_cursor    = r_cursor;
        n_cur_mask  = r_cur_mask;
        n_count     = r_count;
        n_err       = r_err;
        n_full      = r_full;
        n_root_init = r_root_init;
        n_out_valid = r_out_valid;
        n_status    = r_status;
        n_mask_out  = r_mask_out;
        n_node_out  = r_node_out;
        ptr_we      = 1'b0;
        msk_we      = 1'b0;
        msk_waddr   = r_cursor;
        msk_wdata   = r_cur_mask | letter_bit;

        // result taken downstream
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ltrie_pkg::S_IDLE: begin
                if (in_accept) begin
                    n_full = 1'b0;
                    unique case (in_func)
                        ltrie_pkg::FUNC_RESET: begin
                            n_cursor = NW'(0);
                            n_err    = 1'b0;
                        end
                        ltrie_pkg::FUNC_REPORT: begin
                        end
                        ltrie_pkg::FUNC_INSERT,
                        ltrie_pkg::FUNC_LOOKUP: begin
                            if (r_err) begin
                                // ignored while the error is held
                            end else if (letter_oor) begin
                                n_err = 1'b1;
                            end else if (has_child) begin
                                // pointer read issued at ptr_addr
                            end else if (in_func == ltrie_pkg::FUNC_LOOKUP) begin
                                n_err = 1'b1;
                            end else if (pool_full) begin
                                n_full = 1'b1;
                            end else begin
                                // link the fresh node and mark it in the parent mask
                                ptr_we = 1'b1;
                                msk_we = 1'b1;
                                if (r_cursor == NW'(0)) begin
                                    n_root_init = 1'b1;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ltrie_pkg::S_PTR: begin
                n_cursor = ptr_rdata;
            end
            ltrie_pkg::S_MASK: begin
                // root mask is zero until its first write
                if (r_cursor == NW'(0) && !r_root_init) begin
                    n_cur_mask = '0;
                end else begin
                    n_cur_mask = msk_rdata;
                end
            end
            ltrie_pkg::S_ALLOC: begin
                msk_we     = 1'b1;
                msk_waddr  = fresh;
                msk_wdata  = '0;
                n_cursor   = fresh;
                n_cur_mask = '0;
                n_count    = r_count + CW'(1);
            end
            ltrie_pkg::S_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_mask_out  = mask_ext;
                    n_node_out  = node_ext;
                    if (r_err) begin
                        n_status = ltrie_pkg::STATUS_MISSING;
                    end else if (r_full) begin
                        n_status = ltrie_pkg::STATUS_FULL;
                    end else begin
                        n_status = ltrie_pkg::STATUS_OK;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ltrie_pkg::S_IDLE;
            r_cursor    <= '0;
            r_cur_mask  <= '0;
            r_count     <= CW'(1);
            r_err       <= 1'b0;
            r_full      <= 1'b0;
            r_root_init <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cursor    <= n_cursor;
            r_cur_mask  <= n_cur_mask;
            r_count     <= n_count;
            r_err       <= n_err;
            r_full      <= n_full;
            r_root_init <= n_root_init;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_status   <= n_status;
        r_mask_out <= n_mask_out;
        r_node_out <= n_node_out;
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_status;
    assign o_out.child_mask  = r_mask_out;
    assign o_out.cursor_node = r_node_out;

endmodule

/* rtl/ltrie_ram.sv */
// simple dual-port synchronous ram, one write and one registered read per cycle
// no package dependencies
module ltrie_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* tb/tb.sv */
// self-checking testbench for letter_trie_insert_lookup: directed table, then random words
// depends on ltrie_pkg, ltrie_if and the block itself
`timescale 1ns / 1ps

module tb;

    localparam int NODES        = ltrie_pkg::NODES_DEF;
    localparam int ALPHA        = ltrie_pkg::ALPHABET_DEF;
    localparam int ITEMS_TARGET = 1600;
    localparam int PHASE_LEN    = 400;
    localparam int QUIET_LIMIT  = 5000;
    localparam int TAIL_CYCLES  = 16;
    localparam int PRINT_CAP    = 200;

    // one result as it leaves the block
    typedef struct packed {
        logic [ltrie_pkg::STATUS_W-1:0] status;
        logic [ltrie_pkg::MASK_W-1:0]   mask;
        logic [ltrie_pkg::CURSOR_W-1:0] node;
    } t_trie_result;

    // one row of the directed table; typed rows carry their own expected result
    typedef struct packed {
        ltrie_pkg::t_func                func;
        logic [ltrie_pkg::LETTER_W-1:0]  letter;
        logic                            typed;
        t_trie_result                    want;
    } t_stim_row;

    // a word inserted from the root, kept for later lookups
    typedef struct packed {
        logic [4:0]                             len;
        logic [15:0][ltrie_pkg::LETTER_W-1:0]   ch;
    } t_word;

    // traffic shaping for both sides of the block
    typedef enum int {
        TRAFFIC_FREE,
        TRAFFIC_SLOW_SRC,
        TRAFFIC_SLOW_SINK,
        TRAFFIC_BOTH
    } t_traffic;

    // directed part: root report, allocation, lookups, sticky error, bad letters,
    // report and reset ignoring the letter field, following existing children
    localparam t_stim_row DIRECTED_ROWS [0:23] = '{
        {ltrie_pkg::FUNC_REPORT, 5'd31, 1'b1, ltrie_pkg::STATUS_OK,      26'h0,       10'd0},
        {ltrie_pkg::FUNC_INSERT, 5'd0,  1'b1, ltrie_pkg::STATUS_OK,      26'h0,       10'd1},
        {ltrie_pkg::FUNC_INSERT, 5'd25, 1'b1, ltrie_pkg::STATUS_OK,      26'h0,       10'd2},
        {ltrie_pkg::FUNC_RESET,  5'd17, 1'b1, ltrie_pkg::STATUS_OK,      26'h1,       10'd0},
        {ltrie_pkg::FUNC_LOOKUP, 5'd0,  1'b1, ltrie_pkg::STATUS_OK,      26'h2000000, 10'd1},
        {ltrie_pkg::FUNC_LOOKUP, 5'd25, 1'b1, ltrie_pkg::STATUS_OK,      26'h0,       10'd2},
        {ltrie_pkg::FUNC_LOOKUP, 5'd3,  1'b1, ltrie_pkg::STATUS_MISSING, 26'h0,       10'd2},
        {ltrie_pkg::FUNC_INSERT, 5'd4,  1'b1, ltrie_pkg::STATUS_MISSING, 26'h0,       10'd2},
        {ltrie_pkg::FUNC_REPORT, 5'd0,  1'b1, ltrie_pkg::STATUS_MISSING, 26'h0,       10'd2},
        {ltrie_pkg::FUNC_RESET,  5'd0,  1'b1, ltrie_pkg::STATUS_OK,      26'h1,       10'd0},
        {ltrie_pkg::FUNC_INSERT, 5'd26, 1'b1, ltrie_pkg::STATUS_MISSING, 26'h1,       10'd0},
        {ltrie_pkg::FUNC_RESET,  5'd31, 1'b1, ltrie_pkg::STATUS_OK,      26'h1,       10'd0},
        {ltrie_pkg::FUNC_LOOKUP, 5'd31, 1'b1, ltrie_pkg::STATUS_MISSING, 26'h1,       10'd0},
        {ltrie_pkg::FUNC_LOOKUP, 5'd0,  1'b1, ltrie_pkg::STATUS_MISSING, 26'h1,       10'd0},
        {ltrie_pkg::FUNC_RESET,  5'd0,  1'b1, ltrie_pkg::STATUS_OK,      26'h1,       10'd0},
        {ltrie_pkg::FUNC_INSERT, 5'd25, 1'b0, ltrie_pkg::STATUS_OK,      26'h0,       10'd0},
        {ltrie_pkg::FUNC_INSERT, 5'd12, 1'b0, ltrie_pkg::STATUS_OK,      26'h0,       10'd0},
        {ltrie_pkg::FUNC_RESET,  5'd9,  1'b0, ltrie_pkg::STATUS_OK,      26'h0,       10'd0},
        {ltrie_pkg::FUNC_INSERT, 5'd25, 1'b0, ltrie_pkg::STATUS_OK,      26'h0,       10'd0},
        {ltrie_pkg::FUNC_INSERT, 5'd12, 1'b0, ltrie_pkg::STATUS_OK,      26'h0,       10'd0},
        {ltrie_pkg::FUNC_LOOKUP, 5'd0,  1'b0, ltrie_pkg::STATUS_OK,      26'h0,       10'd0},
        {ltrie_pkg::FUNC_RESET,  5'd0,  1'b0, ltrie_pkg::STATUS_OK,      26'h0,       10'd0},
        {ltrie_pkg::FUNC_LOOKUP, 5'd1,  1'b0, ltrie_pkg::STATUS_OK,      26'h0,       10'd0},
        {ltrie_pkg::FUNC_REPORT, 5'd5,  1'b0, ltrie_pkg::STATUS_OK,      26'h0,       10'd0}
    };

    logic i_clk;
    logic i_rst_n;

    ltrie_in_if  cmd_if ();
    ltrie_out_if res_if ();

    letter_trie_insert_lookup dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_if),
        .o_out   (res_if)
    );

    // trie mirror: child pointers, child masks, pool fill, cursor, sticky error
    logic [ltrie_pkg::CURSOR_W-1:0] ptr_model [NODES*ALPHA];
    logic [ltrie_pkg::MASK_W-1:0]   mask_model [NODES];
    int                             nodes_used;
    logic [ltrie_pkg::CURSOR_W-1:0] cursor_model;
    logic                           err_model;

    t_trie_result pending_results [$];
    t_word        known_words [$];

    int       items_sent   = 0;
    int       bad_results  = 0;
    int       quiet_cycles = 0;
    int       tx_idle_pct  = 0;
    int       rx_stall_pct = 0;
    t_traffic traffic      = TRAFFIC_FREE;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // mirror of one command: updates the trie copy and returns the result it causes
    function automatic t_trie_result trie_walk(input ltrie_pkg::t_func f,
                                               input logic [ltrie_pkg::LETTER_W-1:0] l);
        logic [ltrie_pkg::STATUS_W-1:0] st;
        int                             slot_ix;
        st      = ltrie_pkg::STATUS_OK;
        slot_ix = int'(cursor_model) * ALPHA + int'(l);
        if (f == ltrie_pkg::FUNC_RESET) begin
            cursor_model = '0;
            err_model    = 1'b0;
        end else if (f != ltrie_pkg::FUNC_REPORT && !err_model) begin
            if (int'(l) >= ALPHA) begin
                // no child slot for this letter: counts as a missing path
                err_model = 1'b1;
            end else if (mask_model[cursor_model][l]) begin
                cursor_model = ptr_model[slot_ix];
            end else if (f == ltrie_pkg::FUNC_LOOKUP) begin
                err_model = 1'b1;
            end else if (nodes_used >= NODES) begin
                // pool exhausted: insert dropped, not sticky
                st = ltrie_pkg::STATUS_FULL;
            end else begin
                mask_model[nodes_used]       = '0;
                ptr_model[slot_ix]           = ltrie_pkg::CURSOR_W'(nodes_used);
                mask_model[cursor_model][l]  = 1'b1;
                cursor_model                 = ltrie_pkg::CURSOR_W'(nodes_used);
                nodes_used++;
            end
        end
        if (err_model)
            st = ltrie_pkg::STATUS_MISSING;
        return {st, mask_model[cursor_model], cursor_model};
    endfunction

    task automatic flag_result(input string why, input t_trie_result got,
                               input t_trie_result want);
        if (bad_results < PRINT_CAP)
            $display("%0t %s: got status %0d mask %h node %0d, want status %0d mask %h node %0d",
                     $time, why, got.status, got.mask, got.node,
                     want.status, want.mask, want.node);
        bad_results++;
    endtask

    // one command transaction; valid is left high so back-to-back commands need no gap
    task automatic send_cmd(input ltrie_pkg::t_func f,
                            input logic [ltrie_pkg::LETTER_W-1:0] l,
                            input logic typed, input t_trie_result typed_want);
        t_trie_result predicted;
        while ($urandom_range(99) < tx_idle_pct) begin
            cmd_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_if.valid  <= 1'b1;
        cmd_if.func   <= f;
        cmd_if.letter <= l;
        @(posedge i_clk);
        while (!cmd_if.ready)
            @(posedge i_clk);
        // accepted at this edge: the mirror always advances, typed rows override
        predicted = trie_walk(f, l);
        pending_results.push_back(typed ? typed_want : predicted);
        items_sent++;
    endtask

    // hold the command side until every outstanding result has come back
    task automatic drain_results();
        cmd_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_traffic(input t_traffic t);
        traffic = t;
        case (t)
            TRAFFIC_FREE: begin
                tx_idle_pct  = 0;
                rx_stall_pct = 0;
            end
            TRAFFIC_SLOW_SRC: begin
                tx_idle_pct  = 73;
                rx_stall_pct = 0;
            end
            TRAFFIC_SLOW_SINK: begin
                tx_idle_pct  = 0;
                rx_stall_pct = 73;
            end
            default: begin
                tx_idle_pct  = 16;
                rx_stall_pct = 16;
            end
        endcase
    endtask

    // result side: compare each transaction with the oldest prediction, then roll ready
    always @(posedge i_clk) begin : result_check
        t_trie_result got;
        t_trie_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got = {res_if.status, res_if.child_mask, res_if.cursor_node};
            if (pending_results.size() == 0) begin
                flag_result("result with nothing outstanding", got, '0);
            end else begin
                want = pending_results.pop_front();
                if (got !== want)
                    flag_result("result differs", got, want);
            end
        end
        res_if.ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // watchdog: ends the run once nothing has moved on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("letter_trie_insert_lookup: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int    i;
        int    j;
        int    bad;
        int    kind;
        logic  from_root;
        t_word w;

        cmd_if.valid  = 1'b0;
        cmd_if.func   = ltrie_pkg::FUNC_REPORT;
        cmd_if.letter = '0;
        i_rst_n       = 1'b0;

        // mirror state after reset: only the root allocated
        foreach (mask_model[k])
            mask_model[k] = '0;
        nodes_used   = 1;
        cursor_model = '0;
        err_model    = 1'b0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_traffic(TRAFFIC_FREE);
        foreach (DIRECTED_ROWS[r])
            send_cmd(DIRECTED_ROWS[r].func, DIRECTED_ROWS[r].letter,
                     DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);

        // random part: mostly whole words, so the pool fills up well before the end
        while (items_sent < ITEMS_TARGET) begin
            if (t_traffic'((items_sent / PHASE_LEN) % 4) != traffic) begin
                drain_results();
                set_traffic(t_traffic'((items_sent / PHASE_LEN) % 4));
            end
            if ($urandom_range(99) < 2)
                drain_results();

            kind = $urandom_range(99);
            if (kind < 90) begin
                // insert a fresh word, usually from the root, now and then deeper
                from_root = ($urandom_range(3) != 0);
                if (from_root)
                    send_cmd(ltrie_pkg::FUNC_RESET, ltrie_pkg::LETTER_W'($urandom_range(31)),
                             1'b0, '0);
                w.len = 5'($urandom_range(16, 4));
                for (i = 0; i < w.len; i++) begin
                    w.ch[i] = ltrie_pkg::LETTER_W'($urandom_range(ALPHA - 1));
                    send_cmd(ltrie_pkg::FUNC_INSERT, w.ch[i], 1'b0, '0);
                end
                if (from_root)
                    known_words.push_back(w);
                if ($urandom_range(1) != 0)
                    send_cmd(ltrie_pkg::FUNC_REPORT, ltrie_pkg::LETTER_W'($urandom_range(31)),
                             1'b0, '0);
            end else if (kind < 97 && known_words.size() != 0) begin
                // walk a stored word, sometimes with one wrong letter,
                // sometimes growing it further
                w   = known_words[$urandom_range(known_words.size() - 1)];
                bad = ($urandom_range(3) == 0) ? int'($urandom_range(w.len - 1)) : -1;
                send_cmd(ltrie_pkg::FUNC_RESET, ltrie_pkg::LETTER_W'($urandom_range(31)),
                         1'b0, '0);
                for (i = 0; i < w.len; i++)
                    send_cmd(ltrie_pkg::FUNC_LOOKUP,
                             (i == bad) ? ltrie_pkg::LETTER_W'($urandom_range(ALPHA - 1))
                                        : w.ch[i],
                             1'b0, '0);
                if ($urandom_range(2) == 0) begin
                    j = $urandom_range(4, 1);
                    for (i = 0; i < j; i++)
                        send_cmd(ltrie_pkg::FUNC_INSERT,
                                 ltrie_pkg::LETTER_W'($urandom_range(ALPHA - 1)), 1'b0, '0);
                end
                send_cmd(ltrie_pkg::FUNC_REPORT, ltrie_pkg::LETTER_W'($urandom_range(31)),
                         1'b0, '0);
            end else begin
                // noise: any command with any letter, out-of-range ones included
                j = $urandom_range(4, 1);
                for (i = 0; i < j; i++)
                    send_cmd(ltrie_pkg::t_func'($urandom_range(3)),
                             ltrie_pkg::LETTER_W'($urandom_range(31)), 1'b0, '0);
            end
        end

        cmd_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (bad_results == 0) begin
            $display("letter_trie_insert_lookup: match");
        end else begin
            $display("letter_trie_insert_lookup: mismatch");
        end
        $finish;
    end

endmodule

/* letter_trie_insert_lookup.f */
rtl/ltrie_pkg.sv
rtl/ltrie_if.sv
rtl/ltrie_ram.sv
rtl/letter_trie_insert_lookup.sv
tb/tb.sv
